// ===== src/ecdf_pkg.sv =====
// package for the empirical cdf inverse lookup: payload types, opcodes, status codes
package ecdf_pkg;

    localparam int DEFAULT_MAX_ITEMS = 4096;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] load_value;
        logic [31:0] query_fraction;
    } ecdf_in_t;

    typedef struct packed {
        logic [31:0] sampled_value;
        logic [1:0]  status;
    } ecdf_out_t;

endpackage

// ===== src/empirical_cdf_inverse_lookup.sv =====
// empirical cdf table with inverse lookup by binary search and exact interpolation
//
// Clear and load transactions leave the sequencer idle. A query runs through
// these steps after it is accepted: form q*N on the shared 32x32 multiplier,
// binary search steps over the table memory (about log2 of the entry count
// steps, each a registered read and a compare), close the search, fetch the
// matching entry and its predecessor, form the interpolation product in a low
// and a high multiplier pass, set up the serial divider, produce one quotient
// bit per cycle ($clog2(MAX_ITEMS+1)+34 bits, 47 at the default size) and load
// the output register. Exact matches and entry 0 finish right after the
// matching entry is fetched. A query on an empty table goes straight to the
// done state, which loads the output register with an empty status.
// The input is not ready while a query is at work, nor while its result waits
// for a full output register. The result sits in an output register, so loads
// and clears are taken while a result waits. The table memory has no reset:
// only written entries are ever used.
module empirical_cdf_inverse_lookup #(
    parameter int MAX_ITEMS = ecdf_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ecdf_pkg::ecdf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ecdf_pkg::ecdf_out_t m_data
);
    import ecdf_pkg::*;

    // widths follow from the table size
    localparam int CW = $clog2(MAX_ITEMS + 1);  // item count
    localparam int IW = $clog2(MAX_ITEMS);      // table index
    localparam int QW = CW + 32;                // q*N and cumulative count << 32
    localparam int YW = QW + 1;                 // rounded interpolation product
    localparam int NW = YW + 1;                 // divider numerator and quotient
    localparam int KW = $clog2(NW + 1);         // divider bit counter

    typedef enum logic [3:0] {
        S_IDLE, S_QN, S_RD, S_CMP, S_RDHI, S_GOTHI, S_RDPREV, S_GOTPREV,
        S_MUL0, S_MUL1, S_DIVINIT, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    // table memory
    logic [31:0] entry_value_mem [MAX_ITEMS];
    logic [CW-1:0] entry_cum_mem [MAX_ITEMS];
    logic [31:0] rd_val_reg;
    logic [CW-1:0] rd_cnt_reg;

    // table bookkeeping
    logic [CW-1:0] loaded_reg;
    logic [CW-1:0] total_reg;
    logic          overflow_reg;
    logic [31:0]   last_value_reg;

    // query datapath
    logic [31:0]   q_reg;
    logic [QW-1:0] qn_reg;
    logic [IW-1:0] lo_reg, hi_reg;
    logic [31:0]   cur_val_reg, pv_reg, diff_reg;
    logic [CW-1:0] cur_cnt_reg, m_reg, rem_reg;
    logic [QW-1:0] d_reg;
    logic [YW-1:0] y_reg;
    logic [NW-1:0] num_reg;
    logic [KW-1:0] bit_cnt_reg;
    logic [31:0]   res_val_reg;
    logic [1:0]    res_st_reg;

    logic          m_valid_reg;
    ecdf_out_t     m_data_reg;

    logic          accept;
    logic [IW-1:0] mid;
    logic [IW-1:0] rd_addr;
    logic          load_ok, load_dup;
    logic [IW-1:0] wr_addr;
    logic [CW-1:0] wr_cnt;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [CW:0]   trial;
    logic          trial_ge;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // read address follows the sequencer state
    always_comb begin
        case (state_reg)
            S_RDHI:   rd_addr = lo_reg;
            S_RDPREV: rd_addr = lo_reg - 1'b1;
            default:  rd_addr = mid;
        endcase
    end

    // a load either extends the last entry or opens a new one, unless the table is full
    assign load_ok  = accept && (s_data.opcode == OP_LOAD) &&
                      (loaded_reg != CW'(MAX_ITEMS));
    assign load_dup = (total_reg != '0) && (last_value_reg == s_data.load_value);
    assign wr_addr  = load_dup ? IW'(total_reg - 1'b1) : total_reg[IW-1:0];
    assign wr_cnt   = loaded_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            entry_cum_mem[wr_addr] <= wr_cnt;
            if (!load_dup) begin
                entry_value_mem[wr_addr] <= s_data.load_value;
            end
        end
        rd_val_reg <= entry_value_mem[rd_addr];
        rd_cnt_reg <= entry_cum_mem[rd_addr];
    end

    // shared multiplier
    always_comb begin
        case (state_reg)
            S_MUL0:  begin mul_a = d_reg[31:0];         mul_b = diff_reg; end
            S_MUL1:  begin mul_a = 32'(d_reg[QW-1:32]); mul_b = diff_reg; end
            default: begin mul_a = q_reg;               mul_b = 32'(loaded_reg); end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // one restoring division step
    assign trial    = {rem_reg, num_reg[NW-1]};
    assign trial_ge = (trial >= {1'b0, m_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            loaded_reg   <= '0;
            total_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (s_data.opcode)
                            OP_CLEAR: begin
                                loaded_reg   <= '0;
                                total_reg    <= '0;
                                overflow_reg <= 1'b0;
                            end
                            OP_LOAD: begin
                                if (!load_ok) begin
                                    overflow_reg <= 1'b1;
                                end else begin
                                    loaded_reg     <= wr_cnt;
                                    last_value_reg <= s_data.load_value;
                                    if (!load_dup) begin
                                        total_reg <= total_reg + 1'b1;
                                    end
                                end
                            end
                            OP_QUERY: begin
                                if (total_reg == '0 || loaded_reg == '0) begin
                                    res_val_reg <= '0;
                                    res_st_reg  <= ST_EMPTY;
                                    state_reg   <= S_DONE;
                                end else begin
                                    q_reg      <= s_data.query_fraction;
                                    res_st_reg <= overflow_reg ? ST_OVERFLOW : ST_OK;
                                    lo_reg     <= '0;
                                    hi_reg     <= IW'(total_reg - 1'b1);
                                    state_reg  <= S_QN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_QN: begin
                    qn_reg    <= mul_p[QW-1:0];
                    state_reg <= S_RD;
                end
                S_RD: begin
                    // memory latches the midpoint entry
                    state_reg <= (lo_reg == hi_reg) ? S_RDHI : S_CMP;
                end
                S_CMP: begin
                    if ({rd_cnt_reg, 32'b0} >= qn_reg) begin
                        hi_reg <= mid;
                    end else begin
                        lo_reg <= mid + 1'b1;
                    end
                    state_reg <= S_RD;
                end
                S_RDHI: begin
                    state_reg <= S_GOTHI;
                end
                S_GOTHI: begin
                    cur_val_reg <= rd_val_reg;
                    cur_cnt_reg <= rd_cnt_reg;
                    if (lo_reg == '0 || {rd_cnt_reg, 32'b0} == qn_reg) begin
                        res_val_reg <= rd_val_reg;
                        state_reg   <= S_DONE;
                    end else begin
                        state_reg <= S_RDPREV;
                    end
                end
                S_RDPREV: begin
                    state_reg <= S_GOTPREV;
                end
                S_GOTPREV: begin
                    pv_reg   <= rd_val_reg;
                    diff_reg <= cur_val_reg - rd_val_reg;
                    d_reg    <= qn_reg - {rd_cnt_reg, 32'b0};
                    m_reg    <= cur_cnt_reg - rd_cnt_reg;
                    if (cur_cnt_reg == rd_cnt_reg) begin
                        res_val_reg <= cur_val_reg;
                        state_reg   <= S_DONE;
                    end else begin
                        state_reg <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    // low half product, rounded up to the 2^32 unit
                    y_reg     <= YW'(mul_p[63:32]) + YW'(mul_p[31:0] != '0);
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    y_reg     <= y_reg + YW'(mul_p);
                    state_reg <= S_DIVINIT;
                end
                S_DIVINIT: begin
                    // ceiling division: bias numerator by m-1
                    num_reg     <= NW'(y_reg) + NW'(m_reg) - 1'b1;
                    rem_reg     <= '0;
                    bit_cnt_reg <= KW'(NW);
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    rem_reg     <= trial_ge ? CW'(trial - {1'b0, m_reg}) : trial[CW-1:0];
                    num_reg     <= {num_reg[NW-2:0], trial_ge};
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == KW'(1)) begin
                        res_val_reg <= pv_reg + {num_reg[30:0], trial_ge};
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.sampled_value <= res_val_reg;
                        m_data_reg.status        <= res_st_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
